// ===== hw/rtl/mg3_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mg3_pkg
// Shared types and constants of the 3x3 morphological gradient block.
// ----------------------------------------------------------------------------
package mg3_pkg;

   localparam int PIXEL_W   = 8;
   localparam int COORD_W   = 10;
   localparam int DIM_W     = 11;
   localparam int CSR_IDX_W = 1;
   localparam int RSP_DEPTH = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   // One line store entry: a holds the previous row, b the row before that.
   typedef struct packed {
      logic [PIXEL_W-1:0] a;
      logic [PIXEL_W-1:0] b;
   } line_word_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] gradient;
      logic [COORD_W-1:0] center_row;
      logic [COORD_W-1:0] center_col;
      logic               frame_done;
   } rsp_type;

   function automatic logic [PIXEL_W-1:0] max3(input logic [PIXEL_W-1:0] x,
                                               input logic [PIXEL_W-1:0] y,
                                               input logic [PIXEL_W-1:0] z);
      logic [PIXEL_W-1:0] m;
      m = (x > y) ? x : y;
      return (m > z) ? m : z;
   endfunction

endpackage

// ===== hw/rtl/morph_gradient_3x3_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morph_gradient_3x3_top
// Streaming 3x3 morphological gradient: window maximum minus centre pixel.
//
// Pixels enter in raster order on the req_ word channel, one per accepted
// word. Each interior pixel yields one word on the rsp_ channel with its
// gradient, its row and column and a flag on the last interior pixel of the
// frame; border pixels yield nothing. Image size is set through the csr_
// port, and any write restarts the frame at row 0, column 0.
// Throughput is one pixel per clock while req_stall is low. A result becomes
// valid once its pixel has passed the line store read in stage 1, the window
// shift in stage 2 and the queue write; the gradient is formed as it enters the queue.
// The two line stores share one memory word per column, read on accept and
// written back in the following cycle, so the read port sets the one-pixel rate.
// Results wait in a four-word queue. While the receiver stalls, req_stall
// rises once queued plus in-flight words would fill the queue; nothing is
// dropped. Reset clears counters, window and queue and sets each size to its
// maximum, capped at 1024; line store contents are not cleared.
// ----------------------------------------------------------------------------
module morph_gradient_3x3_top #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [mg3_pkg::PIXEL_W-1:0]      req_pixel,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [mg3_pkg::PIXEL_W-1:0]      rsp_gradient,
   output logic [mg3_pkg::COORD_W-1:0]      rsp_center_row,
   output logic [mg3_pkg::COORD_W-1:0]      rsp_center_col,
   output logic                             rsp_frame_done,
   input  logic                             csr_we,
   input  logic [mg3_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mg3_pkg::DIM_W-1:0]        csr_wdata
);
   import mg3_pkg::*;

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int PTR_W = $clog2(RSP_DEPTH);
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);
   localparam logic [WW-1:0] WIDTH_RST  = (MAX_WIDTH < 1024) ? WW'(MAX_WIDTH) : WW'(1024);
   localparam logic [HW-1:0] HEIGHT_RST = (MAX_HEIGHT < 1024) ? HW'(MAX_HEIGHT) : HW'(1024);

   function automatic logic [WW-1:0] clamp_w(input logic [DIM_W-1:0] v);
      if (v < DIM_W'(3)) return WW'(3);
      else if (32'(v) > MAX_WIDTH) return WW'(MAX_WIDTH);
      else return WW'(v);
   endfunction

   function automatic logic [HW-1:0] clamp_h(input logic [DIM_W-1:0] v);
      if (v < DIM_W'(3)) return HW'(3);
      else if (32'(v) > MAX_HEIGHT) return HW'(MAX_HEIGHT);
      else return HW'(v);
   endfunction

   // Size registers and raster counters.
   logic [WW-1:0] width_ff, width_in;
   logic [HW-1:0] height_ff, height_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   // Line store memory and its registered read data.
   line_word_type line_mem [MAX_WIDTH];
   line_word_type rd_ff;

   // Stage 1: pixel waiting for its line store data.
   logic               p1_v_ff, p1_res_ff, p1_done_ff;
   logic [PIXEL_W-1:0] p1_px_ff;
   logic [CW-1:0]      p1_col_ff;
   logic [COORD_W-1:0] p1_crow_ff, p1_ccol_ff;

   // Window, kept as per-column maxima plus the middle row values.
   logic [PIXEL_W-1:0] colmax_ff [3];
   logic [PIXEL_W-1:0] mid1_ff, mid2_ff;

   // Stage 2: result whose window is complete.
   logic               p2_v_ff, p2_done_ff;
   logic [COORD_W-1:0] p2_crow_ff, p2_ccol_ff;

   // Result queue.
   rsp_type            q_ff [RSP_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff, count_in;

   logic               accept, pop, push;
   logic               col_last, row_last, emit, done;
   logic [RW-1:0]      row_m1;
   logic [CW-1:0]      col_m1;
   logic [CNT_W:0]     busy;
   rsp_type            push_word;

   assign accept = req_valid && !req_stall;
   assign pop    = rsp_valid && !rsp_stall;
   assign push   = p2_v_ff;

   assign col_last = (WW'(col_ff) + WW'(1)) >= width_ff;
   assign row_last = (HW'(row_ff) + HW'(1)) >= height_ff;
   assign emit     = (row_ff >= RW'(2)) && (col_ff >= CW'(2));
   assign done     = ((HW'(row_ff) + HW'(1)) == height_ff)
                  && ((WW'(col_ff) + WW'(1)) == width_ff);
   assign row_m1   = row_ff - RW'(1);
   assign col_m1   = col_ff - CW'(1);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = clamp_w(csr_wdata);
            CSR_IMAGE_HEIGHT: height_in = clamp_h(csr_wdata);
            default: ;
         endcase
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

   // Read the column's two stored rows on accept; write back in the next cycle.
   // Consecutive pixels address different columns unless a csr_ write falls between them; there is no forwarding.
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= line_mem[col_ff];
      end
      if (p1_v_ff) begin
         line_mem[p1_col_ff] <= '{a: p1_px_ff, b: rd_ff.a};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
      end else begin
         p1_v_ff <= accept;
      end
      p1_px_ff   <= req_pixel;
      p1_col_ff  <= col_ff;
      p1_res_ff  <= emit;
      p1_done_ff <= done;
      p1_crow_ff <= COORD_W'(row_m1);
      p1_ccol_ff <= COORD_W'(col_m1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         colmax_ff[0] <= '0;
         colmax_ff[1] <= '0;
         colmax_ff[2] <= '0;
         mid1_ff      <= '0;
         mid2_ff      <= '0;
         p2_v_ff      <= 1'b0;
      end else begin
         if (p1_v_ff) begin
            colmax_ff[0] <= colmax_ff[1];
            colmax_ff[1] <= colmax_ff[2];
            colmax_ff[2] <= max3(rd_ff.b, rd_ff.a, p1_px_ff);
            mid1_ff      <= mid2_ff;
            mid2_ff      <= rd_ff.a;
         end
         p2_v_ff <= p1_v_ff && p1_res_ff;
      end
      p2_done_ff <= p1_done_ff;
      p2_crow_ff <= p1_crow_ff;
      p2_ccol_ff <= p1_ccol_ff;
   end

   // The centre is part of the window, so the difference never wraps.
   assign push_word = '{gradient:   max3(colmax_ff[0], colmax_ff[1], colmax_ff[2]) - mid1_ff,
                        center_row: p2_crow_ff,
                        center_col: p2_ccol_ff,
                        frame_done: p2_done_ff};

   assign count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   assign busy     = (CNT_W + 1)'(count_ff) + (CNT_W + 1)'(p1_v_ff) + (CNT_W + 1)'(p2_v_ff);
   assign req_stall = busy >= (CNT_W + 1)'(RSP_DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         count_ff <= count_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= push_word;
      end
   end

   assign rsp_valid      = count_ff != '0;
   assign rsp_gradient   = q_ff[rd_ptr_ff].gradient;
   assign rsp_center_row = q_ff[rd_ptr_ff].center_row;
   assign rsp_center_col = q_ff[rd_ptr_ff].center_col;
   assign rsp_frame_done = q_ff[rd_ptr_ff].frame_done;

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(RSP_DEPTH))
      else $error("result queue occupancy beyond its depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < CNT_W'(RSP_DEPTH)) || pop)
      else $error("result pushed into a full queue");

   a_accept_flows: assert property (@(posedge clock) disable iff (reset)
      accept |=> p1_v_ff)
      else $error("accepted pixel did not reach the line store stage");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      p2_v_ff |-> $past(p1_v_ff))
      else $error("result formed without a pixel behind it");

endmodule
